FILE: hw/rtl/spqt_pkg.sv
`timescale 1ns / 1ps

package spqt_pkg;

    localparam int unsigned PRIO_W = 8;
    localparam int unsigned TID_W  = 8;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [TID_W-1:0]  tid;
    } t_slot;

    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRIO_W-1:0] prio;
        logic [TID_W-1:0]  tid;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/spqt_cell.sv
`timescale 1ns / 1ps

module spqt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spqt_pkg::t_cell_ctrl i_ctrl,
    input  spqt_pkg::t_slot     i_left,
    input  logic                i_left_open,
    input  spqt_pkg::t_slot     i_right,
    output spqt_pkg::t_slot     o_slot,
    output logic                o_open
);
    import spqt_pkg::*;

    logic              r_valid;
    logic [PRIO_W-1:0] r_prio;
    logic [TID_W-1:0]  r_tid;
    t_slot             n_slot;

    assign o_slot = '{valid: r_valid, prio: r_prio, tid: r_tid};
    assign o_open = !r_valid || (r_prio > i_ctrl.prio);

    always_comb begin
        n_slot = o_slot;
        if (i_ctrl.ins) begin
            if (i_left_open) begin
                n_slot = i_left;
            end else if (o_open) begin
                n_slot = '{valid: 1'b1, prio: i_ctrl.prio, tid: i_ctrl.tid};
            end
        end else if (i_ctrl.pop) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_slot.prio;
        r_tid  <= n_slot.tid;
    end

endmodule

FILE: hw/rtl/sorted_priority_task_queue.sv
// A request is accepted into a chain of compare-and-shift slots that all work in
// parallel; its result appears in the output register in the following cycle.
// Throughput: one request per cycle unless an unread reply holds o_ready low.
// Reset: synchronous active-low reset empties the queue and the output register.
`timescale 1ns / 1ps

module sorted_priority_task_queue #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [spqt_pkg::TID_W-1:0]    i_task_id,
    input  logic [spqt_pkg::PRIO_W-1:0]   i_priority_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [spqt_pkg::TID_W-1:0]    o_task_id_res,
    output logic [spqt_pkg::OCC_W-1:0]    o_occupancy
);
    import spqt_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_slot      w_slot [QUEUE_DEPTH];
    logic       w_open [QUEUE_DEPTH];
    t_cell_ctrl w_ctrl;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [TID_W-1:0] r_tid;
    logic [TID_W-1:0] n_tid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = w_slot[QUEUE_DEPTH-1].valid;
    assign w_empty  = !w_slot[0].valid;

    assign w_ctrl.ins  = w_accept && (t_mode'(i_mode) == MODE_INSERT) && !w_full;
    assign w_ctrl.pop  = w_accept && (t_mode'(i_mode) == MODE_POP) && !w_empty;
    assign w_ctrl.prio = i_priority_req;
    assign w_ctrl.tid  = i_task_id;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_open;

        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_open = 1'b0;
        end else begin : g_mid
            assign w_left      = w_slot[g-1];
            assign w_left_open = w_open[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[g+1];
        end

        spqt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_open (w_left_open),
            .i_right     (w_right),
            .o_slot      (w_slot[g]),
            .o_open      (w_open[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_tid    = '0;
        n_status = ST_INSERTED;
        if (t_mode'(i_mode) == MODE_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_POPPED;
                n_tid    = w_slot[0].tid;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_tid    <= n_tid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_task_id_res = r_tid;
    assign o_occupancy   = OCC_W'(r_count);

endmodule

FILE: dv/sorted_priority_task_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_task_queue_tb;
    import spqt_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS = 360;
    localparam int unsigned MAX_REPORTS = 100;

    typedef struct {
        t_mode             mode;
        logic [TID_W-1:0]  tid;
        logic [PRIO_W-1:0] prio;
    } t_request;

    typedef struct {
        t_status           status;
        logic [TID_W-1:0]  tid;
        logic [OCC_W-1:0]  occ;
    } t_reply;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic               i_mode         = 1'b0;
    logic [TID_W-1:0]   i_task_id      = '0;
    logic [PRIO_W-1:0]  i_priority_req = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [1:0]         o_status;
    logic [TID_W-1:0]   o_task_id_res;
    logic [OCC_W-1:0]   o_occupancy;

    t_request           pending_requests[$];
    t_reply             expected_replies[$];
    t_request           next_req;
    t_reply             want;

    logic [PRIO_W-1:0]  sched_prio[QUEUE_DEPTH];
    logic [TID_W-1:0]   sched_tid[QUEUE_DEPTH];
    int                 sched_count  = 0;

    logic               in_fire      = 1'b0;
    int unsigned        tx_idle_pct  = 0;
    int unsigned        rx_idle_pct  = 0;
    int unsigned        stall_seq    = 0;
    int unsigned        stall_seen   = 0;
    int unsigned        hold_left    = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        err_count    = 0;

    sorted_priority_task_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_task_id_res  (o_task_id_res),
        .o_occupancy    (o_occupancy)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic add_request(input t_mode mode, input logic [TID_W-1:0] tid,
                               input logic [PRIO_W-1:0] prio);
        t_request req;
        req.mode = mode;
        req.tid  = tid;
        req.prio = prio;
        pending_requests.push_back(req);
    endtask

    function automatic t_reply predict_queue_op(input t_mode mode,
                                                input logic [TID_W-1:0] tid,
                                                input logic [PRIO_W-1:0] prio);
        t_reply r;
        int     pos;
        int     i;
        r.tid = '0;
        if (mode == MODE_INSERT) begin
            if (sched_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // place ahead of the first strictly larger priority
                pos = sched_count;
                for (i = sched_count - 1; i >= 0; i--) begin
                    if (sched_prio[i] > prio) begin
                        pos = i;
                    end
                end
                for (i = sched_count; i > pos; i--) begin
                    sched_prio[i] = sched_prio[i-1];
                    sched_tid[i]  = sched_tid[i-1];
                end
                sched_prio[pos] = prio;
                sched_tid[pos]  = tid;
                sched_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (sched_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.tid = sched_tid[0];
                for (i = 0; i + 1 < sched_count; i++) begin
                    sched_prio[i] = sched_prio[i+1];
                    sched_tid[i]  = sched_tid[i+1];
                end
                sched_count--;
                r.status = ST_POPPED;
            end
        end
        r.occ = OCC_W'(sched_count);
        return r;
    endfunction

    // advance to the next request once the current one is taken
    always @(negedge i_clk) begin
        if (!i_valid || in_fire) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = pending_requests.pop_front();
                i_valid        <= 1'b1;
                i_mode         <= next_req.mode;
                i_task_id      <= next_req.tid;
                i_priority_req <= next_req.prio;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_seen != stall_seq) begin
            stall_seen <= stall_seq;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with nothing pending: status %0d", o_status));
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                    end
                    if (o_task_id_res !== want.tid) begin
                        report_mismatch($sformatf("task id %0d, want %0d",
                                                  o_task_id_res, want.tid));
                    end
                    if (o_occupancy !== want.occ) begin
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                                                  o_occupancy, want.occ));
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_replies.push_back(predict_queue_op(t_mode'(i_mode), i_task_id,
                                                            i_priority_req));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [PRIO_W-1:0] dir_prio[16];
        t_request          req;
        int unsigned       ins_pct;
        int unsigned       k;
        int unsigned       p;

        dir_prio = '{8'd128, 8'd255, 8'd0, 8'd128, 8'd64, 8'd255,
                     8'd0, 8'd128, 8'd1, 8'd254, 8'd64, 8'd127,
                     8'd128, 8'd0, 8'd200, 8'd255};
        ins_pct = 50;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 77;
                end
                1: begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 34;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // hold the reply side off while requests keep coming
                    stall_seq++;
                end
            endcase

            if (p == 0) begin
                add_request(MODE_POP, 8'hFF, 8'hFF);
                for (k = 0; k < 16; k++) begin
                    add_request(MODE_INSERT, TID_W'(k * 17), dir_prio[k]);
                end
                add_request(MODE_INSERT, 8'hFF, 8'h00);
                add_request(MODE_INSERT, 8'h00, 8'hFF);
                repeat (3) add_request(MODE_POP, 8'h00, 8'h00);
            end

            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0) begin
                    ins_pct = $urandom_range(2) * 30 + 20;
                end
                req.mode = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_POP;
                req.tid  = TID_W'($urandom);
                req.prio = $urandom_range(1) ? PRIO_W'($urandom_range(7))
                                             : PRIO_W'($urandom_range(255));
                pending_requests.push_back(req);
            end

            while (pending_requests.size() != 0) @(posedge i_clk);
        end

        while (i_valid || expected_replies.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
